// File: src/sgpc_pkg.sv
// Shared types, constants and helpers of the shading gain correction unit.
package sgpc_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned OFS_W      = 9;
    localparam int unsigned LW_W       = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned SUM_W      = 12;
    localparam int unsigned SAT_W      = 10;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST = 13'd4096;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_GAIN  = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_PRE_OFFSET  = 2'd1,
        CFG_POST_OFFSET = 2'd2,
        CFG_LINE_WIDTH  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_func               func;
        logic [PIX_W-1:0]    pixel_in;
        logic [IDX_W-1:0]    gain_index;
        logic [GAIN_W-1:0]   gain_value;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel_out;
        logic                end_of_line;
    } t_out_item;

    // Saturate a signed intermediate to the 0..255 pixel range.
    function automatic logic [PIX_W-1:0] clamp_u8(input logic signed [SUM_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed(SUM_W'(255))) begin
            res = '1;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [SUM_W-1:0] sext_ofs(input logic signed [OFS_W-1:0] ofs);
        return {{(SUM_W-OFS_W){ofs[OFS_W-1]}}, ofs};
    endfunction

endpackage

// File: src/sgpc_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface sgpc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/sgpc_gain_mem.sv
// Per-column gain memory: one write port, one registered read port.
module sgpc_gain_mem #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [sgpc_pkg::GAIN_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [sgpc_pkg::GAIN_W-1:0] o_rdata
);
    import sgpc_pkg::*;

    logic [GAIN_W-1:0] r_mem [DEPTH];
    logic [GAIN_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the read data while the stage behind it is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/sgpc_col_ctr.sv
// Column counter with end-of-line detect against the clamped line width.
module sgpc_col_ctr #(
    parameter int unsigned MAX_WIDTH = 4096,
    parameter int unsigned ADDR_W    = 12,
    parameter int unsigned CMP_W     = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic [sgpc_pkg::LW_W-1:0] i_line_width,
    output logic [ADDR_W-1:0]         o_col,
    output logic                      o_eol
);
    import sgpc_pkg::*;

    logic [ADDR_W-1:0] r_col;
    logic [ADDR_W-1:0] n_col;
    logic [CMP_W-1:0]  w_lw;
    logic [CMP_W-1:0]  w_width;
    logic [CMP_W-1:0]  w_col_inc;

    always_comb begin
        w_lw = CMP_W'(i_line_width);
        // Zero means one pixel per line; anything past the memory saturates.
        if (w_lw == '0) begin
            w_width = CMP_W'(1);
        end else if (w_lw > CMP_W'(MAX_WIDTH)) begin
            w_width = CMP_W'(MAX_WIDTH);
        end else begin
            w_width = w_lw;
        end
        w_col_inc = CMP_W'(r_col) + CMP_W'(1);
        o_eol     = (w_col_inc >= w_width);
        n_col     = o_eol ? '0 : w_col_inc[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;
endmodule

// File: src/sgpc_correct.sv
// Gain multiply, fraction drop, saturate and post-offset of one pixel, or the raw pixel when disabled.
module sgpc_correct #(
    parameter int unsigned GAIN_FRAC_BITS = 12
) (
    input  logic                              i_enable,
    input  logic [sgpc_pkg::PIX_W-1:0]        i_pix,
    input  logic [sgpc_pkg::PIX_W-1:0]        i_pre_clamped,
    input  logic [sgpc_pkg::GAIN_W-1:0]       i_gain,
    input  logic signed [sgpc_pkg::OFS_W-1:0] i_post_offset,
    output logic [sgpc_pkg::PIX_W-1:0]        o_pixel
);
    import sgpc_pkg::*;

    localparam int unsigned PROD_W = PIX_W + GAIN_W;

    logic [PROD_W-1:0]       w_prod;
    logic [PROD_W-1:0]       w_shifted;
    logic [SAT_W-1:0]        w_sat;
    logic signed [SUM_W-1:0] w_sum;

    always_comb begin
        w_prod    = PROD_W'(i_pre_clamped) * PROD_W'(i_gain);
        w_shifted = w_prod >> GAIN_FRAC_BITS;
        // Cap the scaled value at 1023 before the post-offset.
        if (|w_shifted[PROD_W-1:SAT_W]) begin
            w_sat = '1;
        end else begin
            w_sat = w_shifted[SAT_W-1:0];
        end
        w_sum   = $signed({{(SUM_W-SAT_W){1'b0}}, w_sat}) + sext_ofs(i_post_offset);
        o_pixel = i_enable ? clamp_u8(w_sum) : i_pix;
    end
endmodule

// File: src/shading_gain_pixel_correction_unit.sv
// Top level of the per-column shading gain correction unit.
//
//  channel     dir  payload                                      handshake
//  i_pix_in    in   func, pixel_in, gain_index, gain_value      valid/ready
//  o_pix_out   out  pixel_out, end_of_line                      valid/ready
//  i_cfg_*     in   idx 0 enable, 1 pre, 2 post, 3 line width   write enable
//
// One beat is taken per cycle while ready is high; a pixel beat passes through
// the gain memory read stage, then the multiply and output register.
// A gain write beat uses one input slot and gives no result.
// Reset clears the pipeline valids, the column counter and the config registers; the
// gain memory is not cleared and must be written before its columns are used.
// Ready drops only when both stages hold a beat and the output is not taken.
module shading_gain_pixel_correction_unit #(
    parameter int unsigned MAX_WIDTH      = 4096,
    parameter int unsigned GAIN_FRAC_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sgpc_stream_if.sink                     i_pix_in,
    sgpc_stream_if.source                   o_pix_out,
    input  logic                            i_cfg_we,
    input  logic [sgpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sgpc_pkg::*;

    localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
    localparam int unsigned CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMP_W  = (CNT_W > LW_W) ? CNT_W : LW_W;

    // Configuration registers
    logic                    r_enable;
    logic signed [OFS_W-1:0] r_pre_offset;
    logic signed [OFS_W-1:0] r_post_offset;
    logic [LW_W-1:0]         r_line_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_pre_offset  <= '0;
            r_post_offset <= '0;
            r_line_width  <= LINE_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_ENABLE:      r_enable      <= i_cfg_data[0];
                CFG_PRE_OFFSET:  r_pre_offset  <= i_cfg_data[OFS_W-1:0];
                CFG_POST_OFFSET: r_post_offset <= i_cfg_data[OFS_W-1:0];
                CFG_LINE_WIDTH:  r_line_width  <= i_cfg_data[LW_W-1:0];
            endcase
        end
    end

    // Handshake
    t_in_item  w_in;
    logic      w_in_fire;
    logic      w_pix_fire;
    logic      w_gain_fire;
    logic      w_out_free;
    logic      w_s1_free;
    logic      w_s1_move;

    logic      r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] r_s1_pre;
    logic      r_s1_eol;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign w_in        = i_pix_in.payload;
    assign w_out_free  = !r_out_valid || o_pix_out.ready;
    assign w_s1_free   = !r_s1_valid || w_out_free;
    assign w_s1_move   = r_s1_valid && w_out_free;
    assign w_in_fire   = i_pix_in.valid && w_s1_free;
    assign w_pix_fire  = w_in_fire && (w_in.func == FUNC_PIXEL);
    assign w_gain_fire = w_in_fire && (w_in.func == FUNC_GAIN);

    assign i_pix_in.ready    = w_s1_free;
    assign o_pix_out.valid   = r_out_valid;
    assign o_pix_out.payload = r_out_item;

    // Gain memory write path; drop writes beyond the memory depth
    logic [CMP_W-1:0]  w_widx;
    logic              w_widx_ok;
    logic [ADDR_W-1:0] w_col;
    logic              w_eol;
    logic [GAIN_W-1:0] w_gain;

    assign w_widx    = CMP_W'(w_in.gain_index);
    assign w_widx_ok = (w_widx < CMP_W'(MAX_WIDTH));

    sgpc_gain_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_gain_mem (
        .i_clk   (i_clk),
        .i_we    (w_gain_fire && w_widx_ok),
        .i_waddr (w_widx[ADDR_W-1:0]),
        .i_wdata (w_in.gain_value),
        .i_re    (w_pix_fire),
        .i_raddr (w_col),
        .o_rdata (w_gain)
    );

    sgpc_col_ctr #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W),
        .CMP_W     (CMP_W)
    ) u_col_ctr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_pix_fire),
        .i_line_width (r_line_width),
        .o_col        (w_col),
        .o_eol        (w_eol)
    );

    // Pre-offset and clamp ahead of the memory read stage
    logic [PIX_W-1:0] w_pre;
    assign w_pre = clamp_u8($signed({{(SUM_W-PIX_W){1'b0}}, w_in.pixel_in})
                            + sext_ofs(r_pre_offset));

    logic [PIX_W-1:0] w_corr;

    sgpc_correct #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_correct (
        .i_enable      (r_enable),
        .i_pix         (r_s1_pix),
        .i_pre_clamped (r_s1_pre),
        .i_gain        (w_gain),
        .i_post_offset (r_post_offset),
        .o_pixel       (w_corr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= w_pix_fire;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pix_fire) begin
            r_s1_pix <= w_in.pixel_in;
            r_s1_pre <= w_pre;
            r_s1_eol <= w_eol;
        end
        // Advance the finished beat into the output register
        if (w_s1_move) begin
            r_out_item.pixel_out   <= w_corr;
            r_out_item.end_of_line <= r_s1_eol;
        end
    end
endmodule
